/* rtl/core/dcp_pkg.sv */
// ----------------------------------------------------------------------------
// dcp_pkg: shared constants for the distance constraint projection
// Field widths, pipeline stage counts, divider geometry and register indexes.
// ----------------------------------------------------------------------------
package dcp_pkg;

   // payload widths
   localparam int POS_W  = 24;   // signed Q15.8 position
   localparam int WGT_W  = 16;   // unsigned Q8.8 inverse mass
   localparam int WS_W   = WGT_W + 1;
   localparam int MAG_W  = 24;   // |p1 - p2| per axis
   localparam int SQ_W   = 2 * MAG_W;
   localparam int RAD_W  = 64;   // radicand, Q.30
   localparam int ROOT_W = 32;   // separation, Q.15
   localparam int REM_W  = ROOT_W + 2;
   localparam int ERR_W  = 32;   // |error| magnitude
   localparam int SQRT_STAGES = ROOT_W;

   // configuration
   localparam int REST_W     = 24;
   localparam int K_W        = 17;
   localparam logic [K_W-1:0] K_ONE = 17'd65536;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STIFFNESS   = 1'd1;

   // restoring divider geometry (quotient known to stay below 2^DIV_Q_W)
   localparam int DIV_N_W    = 61;
   localparam int DIV_D_W    = 32;
   localparam int DIV_Q_W    = 31;
   localparam int DIV_STAGES = DIV_Q_W;

   // rounding Q.13 -> Q.8
   localparam int RND_SHIFT = 5;

endpackage

/* rtl/core/dcp_div.sv */
// ----------------------------------------------------------------------------
// dcp_div: pipelined restoring divider
// One quotient bit per stage; the quotient must fit in DIV_Q_W bits.
// ----------------------------------------------------------------------------
module dcp_div (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [dcp_pkg::DIV_N_W-1:0]  dividend,
   input  logic [dcp_pkg::DIV_D_W-1:0]  divisor,
   output logic [dcp_pkg::DIV_Q_W-1:0]  quotient
);
   import dcp_pkg::*;

   typedef struct packed {
      logic [DIV_D_W-1:0] rem;   // partial remainder, below divisor
      logic [DIV_Q_W-1:0] low;   // unused dividend bits, quotient shifts in
      logic [DIV_D_W-1:0] den;
   } div_stage_type;

   div_stage_type st_ff [DIV_STAGES];
   div_stage_type st_in [DIV_STAGES];
   div_stage_type head;

   function automatic div_stage_type div_step(input div_stage_type s);
      logic [DIV_D_W:0] trial;
      logic [DIV_D_W:0] diff;
      logic             ge;
      div_stage_type    o;
      trial = {s.rem, s.low[DIV_Q_W-1]};
      diff  = trial - {1'b0, s.den};
      ge    = (trial >= {1'b0, s.den});
      o.rem = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      o.low = {s.low[DIV_Q_W-2:0], ge};
      o.den = s.den;
      return o;
   endfunction

   // first stage starts from the high dividend bits
   always_comb begin
      head.rem = DIV_D_W'(dividend[DIV_N_W-1:DIV_Q_W]);
      head.low = dividend[DIV_Q_W-1:0];
      head.den = divisor;
      st_in[0] = div_step(head);
      for (int j = 1; j < DIV_STAGES; j++) begin
         st_in[j] = div_step(st_ff[j-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < DIV_STAGES; j++) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   assign quotient = st_ff[DIV_STAGES-1].low;

endmodule

/* rtl/core/distance_constraint_projection.sv */
// ----------------------------------------------------------------------------
// distance_constraint_projection: PBD distance constraint solver step
// Moves two particles along their joining line toward the rest length.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one constraint (two Q15.8 positions, two Q8.8 inverse
//   masses); rsp_* returns the corrected positions and a skip flag. A
//   transfer happens on a rising edge with valid high and stall low.
//   csr_write loads rest_length (index 0) or stiffness_factor (index 1);
//   write only while no constraint is in flight.
// Pipeline: the item passes 103 registers (input capture at the transfer
//   edge, squares, radicand, 32 square root stages, error, products, 31
//   divider stages, stiffness scale, weight products, 31 divider stages,
//   rounding, output); rsp_valid comes from the output register.
// Throughput: one constraint per cycle while req_stall is low; every stage is a register stage.
// Stall: while a response waits under rsp_stall the pipeline keeps moving
//   as long as its last stage is empty; otherwise the whole pipeline holds
//   and req_stall rises.
// Reset: all valid bits clear, rest_length = 0, stiffness_factor = one.
// ----------------------------------------------------------------------------
module distance_constraint_projection (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [dcp_pkg::POS_W-1:0]      req_first_x,
   input  logic signed [dcp_pkg::POS_W-1:0]      req_first_y,
   input  logic signed [dcp_pkg::POS_W-1:0]      req_second_x,
   input  logic signed [dcp_pkg::POS_W-1:0]      req_second_y,
   input  logic        [dcp_pkg::WGT_W-1:0]      req_first_inv_mass,
   input  logic        [dcp_pkg::WGT_W-1:0]      req_second_inv_mass,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dcp_pkg::POS_W-1:0]      rsp_new_first_x,
   output logic signed [dcp_pkg::POS_W-1:0]      rsp_new_first_y,
   output logic signed [dcp_pkg::POS_W-1:0]      rsp_new_second_x,
   output logic signed [dcp_pkg::POS_W-1:0]      rsp_new_second_y,
   output logic                                  rsp_skipped,
   input  logic                                  csr_write,
   input  logic        [dcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [dcp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dcp_pkg::*;

   // stage map
   localparam int ST_SQ    = 1;
   localparam int ST_RAD   = 2;
   localparam int ST_SQRT0 = ST_RAD + 1;
   localparam int ST_ERR   = ST_SQRT0 + SQRT_STAGES;
   localparam int ST_PROD  = ST_ERR + 1;
   localparam int ST_DIV1  = ST_PROD + 1;
   localparam int ST_V     = ST_DIV1 + DIV_STAGES;
   localparam int ST_WPROD = ST_V + 1;
   localparam int ST_DIV2  = ST_WPROD + 1;
   localparam int ST_RND   = ST_DIV2 + DIV_STAGES;
   localparam int NSTAGE   = ST_RND + 1;
   localparam int LAST     = NSTAGE - 1;

   localparam int RES_W = POS_W + 5;
   localparam int RND_W = DIV_Q_W + 1 - RND_SHIFT;
   localparam logic [DIV_Q_W:0] RND_HALF = (DIV_Q_W + 1)'(1 << (RND_SHIFT - 1));
   localparam logic signed [RES_W-1:0] POS_MAX = RES_W'((1 << (POS_W - 1)) - 1);
   localparam logic signed [RES_W-1:0] POS_MIN = -RES_W'(1 << (POS_W - 1));

   // data that rides along with each constraint
   typedef struct packed {
      logic signed [POS_W-1:0] x1;
      logic signed [POS_W-1:0] y1;
      logic signed [POS_W-1:0] x2;
      logic signed [POS_W-1:0] y2;
      logic [WGT_W-1:0]        w1;
      logic [WGT_W-1:0]        w2;
      logic [WS_W-1:0]         ws;
      logic [MAG_W-1:0]        adx;
      logic [MAG_W-1:0]        ady;
      logic                    dxn;
      logic                    dyn;
      logic [ROOT_W-1:0]       d;
      logic                    en;
      logic                    skip;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } sq_type;

   function automatic sq_type sqrt_step(input sq_type s);
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      sq_type           o;
      cur   = {s.rem, s.rad[RAD_W-1:RAD_W-2]};
      trial = {2'b00, s.root, 2'b01};
      diff  = cur - trial;
      if (cur >= trial) begin
         o.rem  = diff[REM_W-1:0];
         o.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         o.rem  = cur[REM_W-1:0];
         o.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      o.rad = {s.rad[RAD_W-3:0], 2'b00};
      return o;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [RES_W-1:0] v);
      logic signed [POS_W-1:0] o;
      if (v > POS_MAX) begin
         o = POS_MAX[POS_W-1:0];
      end else if (v < POS_MIN) begin
         o = POS_MIN[POS_W-1:0];
      end else begin
         o = v[POS_W-1:0];
      end
      return o;
   endfunction

   // configuration registers
   logic [REST_W-1:0] rest_ff;
   logic [K_W-1:0]    stiff_ff;
   logic [K_W-1:0]    kc;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff  <= '0;
         stiff_ff <= K_ONE;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_REST_LENGTH: rest_ff  <= csr_wdata[REST_W-1:0];
            CSR_STIFFNESS:   stiff_ff <= K_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   assign kc = (stiff_ff > K_ONE) ? K_ONE : stiff_ff;

   // pipeline control
   logic [NSTAGE-1:0] vld_ff;
   logic              rsp_valid_ff;
   logic              adv;
   logic              load_out;

   assign load_out  = !(rsp_valid_ff && rsp_stall);
   assign adv       = !(vld_ff[LAST] && rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], req_valid};
      end
   end

   // sideband line
   side_type            side_ff [NSTAGE];
   side_type            side_in [NSTAGE];
   logic signed [POS_W:0] dx_in;
   logic signed [POS_W:0] dy_in;
   logic [POS_W:0]      dx_neg;
   logic [POS_W:0]      dy_neg;
   sq_type              sq_ff [SQRT_STAGES];
   sq_type              sq_in [SQRT_STAGES];
   sq_type              sq_head;
   logic [ROOT_W-1:0]   d_res;
   logic [ERR_W+1:0]    err_in;
   logic [ERR_W+1:0]    err_neg;
   logic [ERR_W-1:0]    em_ff;

   assign dx_in  = {req_first_x[POS_W-1], req_first_x} - {req_second_x[POS_W-1], req_second_x};
   assign dy_in  = {req_first_y[POS_W-1], req_first_y} - {req_second_y[POS_W-1], req_second_y};
   assign dx_neg = (POS_W + 1)'(0) - dx_in;
   assign dy_neg = (POS_W + 1)'(0) - dy_in;
   assign d_res  = sq_ff[SQRT_STAGES-1].root;

   always_comb begin
      side_in[0].x1   = req_first_x;
      side_in[0].y1   = req_first_y;
      side_in[0].x2   = req_second_x;
      side_in[0].y2   = req_second_y;
      side_in[0].w1   = req_first_inv_mass;
      side_in[0].w2   = req_second_inv_mass;
      side_in[0].ws   = '0;
      side_in[0].dxn  = dx_in[POS_W];
      side_in[0].dyn  = dy_in[POS_W];
      side_in[0].adx  = dx_in[POS_W] ? dx_neg[MAG_W-1:0] : dx_in[MAG_W-1:0];
      side_in[0].ady  = dy_in[POS_W] ? dy_neg[MAG_W-1:0] : dy_in[MAG_W-1:0];
      side_in[0].d    = '0;
      side_in[0].en   = 1'b0;
      side_in[0].skip = 1'b0;
      for (int i = 1; i < NSTAGE; i++) begin
         side_in[i] = side_ff[i-1];
      end
      // weight sum
      side_in[ST_SQ].ws = {1'b0, side_ff[ST_SQ-1].w1} + {1'b0, side_ff[ST_SQ-1].w2};
      // separation and pass-through decision
      side_in[ST_ERR].d    = d_res;
      side_in[ST_ERR].en   = err_in[ERR_W+1];
      side_in[ST_ERR].skip = (side_ff[ST_ERR-1].ws == '0) || (d_res == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NSTAGE; i++) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   // squares and radicand (dx^2 + dy^2) << 14
   logic [SQ_W-1:0]  sqx_ff, sqy_ff;
   logic [SQ_W:0]    sq_sum;
   logic [RAD_W-1:0] rad_ff;

   assign sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= SQ_W'(side_ff[ST_SQ-1].adx) * SQ_W'(side_ff[ST_SQ-1].adx);
         sqy_ff <= SQ_W'(side_ff[ST_SQ-1].ady) * SQ_W'(side_ff[ST_SQ-1].ady);
         rad_ff <= RAD_W'({sq_sum, 14'b0});
      end
   end

   // square root, one result bit per stage
   always_comb begin
      sq_head.rem  = '0;
      sq_head.root = '0;
      sq_head.rad  = rad_ff;
      sq_in[0] = sqrt_step(sq_head);
      for (int j = 1; j < SQRT_STAGES; j++) begin
         sq_in[j] = sqrt_step(sq_ff[j-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < SQRT_STAGES; j++) begin
            sq_ff[j] <= sq_in[j];
         end
      end
   end

   // error against rest length, magnitude and sign
   assign err_in  = {2'b00, d_res} - {3'b000, rest_ff, 7'b0};
   assign err_neg = (ERR_W + 2)'(0) - err_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         em_ff <= err_in[ERR_W+1] ? err_neg[ERR_W-1:0] : err_in[ERR_W-1:0];
      end
   end

   // |e| * |a|
   localparam int PE_W = ERR_W + MAG_W;
   logic [PE_W-1:0] pex_ff, pey_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pex_ff <= PE_W'(em_ff) * PE_W'(side_ff[ST_PROD-1].adx);
         pey_ff <= PE_W'(em_ff) * PE_W'(side_ff[ST_PROD-1].ady);
      end
   end

   // u = (|e| * |a| << 5) / d
   logic [DIV_Q_W-1:0] ux, uy;

   dcp_div u_div_ux (
      .clock    (clock),
      .advance  (adv),
      .dividend ({pex_ff, 5'b0}),
      .divisor  (side_ff[ST_PROD].d),
      .quotient (ux)
   );

   dcp_div u_div_uy (
      .clock    (clock),
      .advance  (adv),
      .dividend ({pey_ff, 5'b0}),
      .divisor  (side_ff[ST_PROD].d),
      .quotient (uy)
   );

   // v = u * k >> 16
   localparam int UK_W = DIV_Q_W + K_W;
   logic [UK_W-1:0]    ukx, uky;
   logic [DIV_Q_W-1:0] vx_ff, vy_ff;

   assign ukx = UK_W'(ux) * UK_W'(kc);
   assign uky = UK_W'(uy) * UK_W'(kc);

   always_ff @(posedge clock) begin
      if (adv) begin
         vx_ff <= ukx[DIV_Q_W+15:16];
         vy_ff <= uky[DIV_Q_W+15:16];
      end
   end

   // v * w per particle and axis
   localparam int VW_W = DIV_Q_W + WGT_W;
   logic [VW_W-1:0] vw1x_ff, vw1y_ff, vw2x_ff, vw2y_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         vw1x_ff <= VW_W'(vx_ff) * VW_W'(side_ff[ST_WPROD-1].w1);
         vw1y_ff <= VW_W'(vy_ff) * VW_W'(side_ff[ST_WPROD-1].w1);
         vw2x_ff <= VW_W'(vx_ff) * VW_W'(side_ff[ST_WPROD-1].w2);
         vw2y_ff <= VW_W'(vy_ff) * VW_W'(side_ff[ST_WPROD-1].w2);
      end
   end

   // c = v * w / (w1 + w2)
   logic [DIV_Q_W-1:0] c1x, c1y, c2x, c2y;
   logic [DIV_D_W-1:0] ws_den;

   assign ws_den = DIV_D_W'(side_ff[ST_WPROD].ws);

   dcp_div u_div_c1x (
      .clock    (clock),
      .advance  (adv),
      .dividend (DIV_N_W'(vw1x_ff)),
      .divisor  (ws_den),
      .quotient (c1x)
   );

   dcp_div u_div_c1y (
      .clock    (clock),
      .advance  (adv),
      .dividend (DIV_N_W'(vw1y_ff)),
      .divisor  (ws_den),
      .quotient (c1y)
   );

   dcp_div u_div_c2x (
      .clock    (clock),
      .advance  (adv),
      .dividend (DIV_N_W'(vw2x_ff)),
      .divisor  (ws_den),
      .quotient (c2x)
   );

   dcp_div u_div_c2y (
      .clock    (clock),
      .advance  (adv),
      .dividend (DIV_N_W'(vw2y_ff)),
      .divisor  (ws_den),
      .quotient (c2y)
   );

   // round Q.13 -> Q.8
   logic [DIV_Q_W:0] s1x, s1y, s2x, s2y;
   logic [RND_W-1:0] r1x_ff, r1y_ff, r2x_ff, r2y_ff;

   assign s1x = {1'b0, c1x} + RND_HALF;
   assign s1y = {1'b0, c1y} + RND_HALF;
   assign s2x = {1'b0, c2x} + RND_HALF;
   assign s2y = {1'b0, c2y} + RND_HALF;

   always_ff @(posedge clock) begin
      if (adv) begin
         r1x_ff <= s1x[DIV_Q_W:RND_SHIFT];
         r1y_ff <= s1y[DIV_Q_W:RND_SHIFT];
         r2x_ff <= s2x[DIV_Q_W:RND_SHIFT];
         r2y_ff <= s2y[DIV_Q_W:RND_SHIFT];
      end
   end

   // apply corrections, saturate, pass through skipped items
   side_type                fin;
   logic                    negx, negy;
   logic signed [RES_W-1:0] x1e, y1e, x2e, y2e;
   logic signed [RES_W-1:0] r1xe, r1ye, r2xe, r2ye;
   logic signed [RES_W-1:0] n1x, n1y, n2x, n2y;

   assign fin  = side_ff[LAST];
   assign negx = fin.en ^ fin.dxn;
   assign negy = fin.en ^ fin.dyn;
   assign x1e  = RES_W'(fin.x1);
   assign y1e  = RES_W'(fin.y1);
   assign x2e  = RES_W'(fin.x2);
   assign y2e  = RES_W'(fin.y2);
   assign r1xe = $signed({{(RES_W-RND_W){1'b0}}, r1x_ff});
   assign r1ye = $signed({{(RES_W-RND_W){1'b0}}, r1y_ff});
   assign r2xe = $signed({{(RES_W-RND_W){1'b0}}, r2x_ff});
   assign r2ye = $signed({{(RES_W-RND_W){1'b0}}, r2y_ff});
   assign n1x  = negx ? x1e + r1xe : x1e - r1xe;
   assign n1y  = negy ? y1e + r1ye : y1e - r1ye;
   assign n2x  = negx ? x2e - r2xe : x2e + r2xe;
   assign n2y  = negy ? y2e - r2ye : y2e + r2ye;

   logic signed [POS_W-1:0] new_x1_ff, new_y1_ff, new_x2_ff, new_y2_ff;
   logic                    skipped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         skipped_ff <= fin.skip;
         new_x1_ff  <= fin.skip ? fin.x1 : sat_pos(n1x);
         new_y1_ff  <= fin.skip ? fin.y1 : sat_pos(n1y);
         new_x2_ff  <= fin.skip ? fin.x2 : sat_pos(n2x);
         new_y2_ff  <= fin.skip ? fin.y2 : sat_pos(n2y);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_first_x  = new_x1_ff;
   assign rsp_new_first_y  = new_y1_ff;
   assign rsp_new_second_x = new_x2_ff;
   assign rsp_new_second_y = new_y2_ff;
   assign rsp_skipped      = skipped_ff;

   // checks
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !vld_ff[0] && !vld_ff[LAST])
      else $error("pipeline valid bits not cleared by reset");

   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAST] && rsp_valid && rsp_stall) |=> vld_ff[LAST])
      else $error("finished item dropped while response stalled");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !vld_ff[LAST]) |=> !rsp_valid)
      else $error("response produced with no item behind it");

endmodule

/* tb/sv/distance_constraint_projection_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_constraint_projection_tb: self-checking bench for the PBD step
// Streams constraints through the block under random idling on both sides,
// predicts each corrected particle pair in fixed point and compares every
// response in order, all fields at once. Registers change only while idle.
// ----------------------------------------------------------------------------
module distance_constraint_projection_tb;
   import dcp_pkg::*;

   localparam int LATENCY   = 103;
   localparam int WDOG_MAX  = 20000;
   localparam int NUM_RAND  = 1900;

   typedef struct packed {
      logic signed [POS_W-1:0] x1, y1, x2, y2;
      logic [WGT_W-1:0]        w1, w2;
   } pair_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x1, y1, x2, y2;
      logic                    skip;
   } moved_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [POS_W-1:0] req_first_x = '0, req_first_y = '0;
   logic signed [POS_W-1:0] req_second_x = '0, req_second_y = '0;
   logic [WGT_W-1:0] req_first_inv_mass = '0, req_second_inv_mass = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [POS_W-1:0] rsp_new_first_x, rsp_new_first_y;
   logic signed [POS_W-1:0] rsp_new_second_x, rsp_new_second_y;
   logic rsp_skipped;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   distance_constraint_projection dut (.*);

   always #10 clock = ~clock;

   // bench copy of the registers
   logic [REST_W-1:0] rest_len_q = '0;
   logic [K_W-1:0]    stiff_q    = K_ONE;

   pair_type    pending_q[$];
   moved_type   expected_moves[$];
   int  mismatches = 0;
   int  wdog = 0;
   bit  calm = 1'b0;   // no idling in the last part
   int  drv_gap = 0, mon_gap = 0;

   // transfer seen at the rising edge, consumed at the next falling edge
   logic req_stall_q = 1'b1;
   bit   hold_off = 1'b0;

   function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint axis_shift(logic [63:0] em, bit eneg, longint a,
                                         logic [63:0] d, logic [63:0] k,
                                         logic [63:0] w, logic [63:0] ws);
      logic [63:0] am, u, v, c, r;
      am = (a < 0) ? -a : a;
      u = ((em * am) << 5) / d;
      v = (u * k) >> 16;
      c = (v * w) / ws;
      r = (c + 16) >> 5;
      return (eneg != (a < 0)) ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic [POS_W-1:0] clamp_pos(longint v);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[POS_W-1:0];
   endfunction

   function automatic moved_type project_pair(pair_type c);
      moved_type m;
      longint x1, y1, x2, y2, dx, dy, err;
      logic [63:0] ws, d, k, em, adx, ady;
      bit en;
      x1 = c.x1; y1 = c.y1; x2 = c.x2; y2 = c.y2;
      ws = c.w1 + c.w2;
      dx = x1 - x2; dy = y1 - y2;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      d = isqrt((adx * adx + ady * ady) << 14);
      k = (stiff_q > K_ONE) ? K_ONE : stiff_q;
      m = '{c.x1, c.y1, c.x2, c.y2, 1'b1};
      if (ws != 0 && d != 0) begin
         err = longint'(d) - longint'({40'd0, rest_len_q} << 7);
         en = err < 0;
         em = en ? -err : err;
         m.x1 = clamp_pos(x1 - axis_shift(em, en, dx, d, k, c.w1, ws));
         m.y1 = clamp_pos(y1 - axis_shift(em, en, dy, d, k, c.w1, ws));
         m.x2 = clamp_pos(x2 + axis_shift(em, en, dx, d, k, c.w2, ws));
         m.y2 = clamp_pos(y2 + axis_shift(em, en, dy, d, k, c.w2, ws));
         m.skip = 1'b0;
      end
      return m;
   endfunction

   // driver: one transfer per accepted edge, random bursts of idling
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall_q) begin
            expected_moves.push_back(project_pair(pending_q.pop_front()));
         end
         if (req_valid && req_stall_q) begin
            // hold the stalled payload
         end else if (drv_gap > 0) begin
            drv_gap <= drv_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0 && !hold_off) begin
            if (!calm && $urandom_range(0, 9) == 0) begin
               drv_gap <= $urandom_range(0, 15);
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               {req_first_x, req_first_y, req_second_x, req_second_y,
                req_first_inv_mass, req_second_inv_mass} <= pending_q[0];
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) req_stall_q <= req_stall;

   // response stall bursts
   always @(negedge clock) begin
      if (!reset) begin
         if (mon_gap > 0) begin
            mon_gap <= mon_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            mon_gap <= $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      moved_type got, want;
      if (reset) begin
         wdog <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) wdog <= 0;
         else wdog <= wdog + 1;
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_new_first_x, rsp_new_first_y, rsp_new_second_x,
                    rsp_new_second_y, rsp_skipped};
            if (expected_moves.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", got);
            end else begin
               want = expected_moves.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p got %p", want, got);
               end
            end
         end
         if (wdog > WDOG_MAX) begin
            $display("FAIL distance_constraint_projection");
            $finish;
         end
      end
   end

   function automatic logic [POS_W-1:0] rand_pos(int span);
      case ($urandom_range(0, 3))
         0: return POS_W'($urandom);
         1: return $urandom_range(0, 1) ? POS_W'(24'h7FFFFF - $urandom_range(0, span))
                                        : POS_W'(24'h800000 + $urandom_range(0, span));
         default: return POS_W'($signed($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   function automatic pair_type rand_pair();
      pair_type c;
      c.x1 = rand_pos(4000); c.y1 = rand_pos(4000);
      c.x2 = POS_W'(c.x1 + $signed($urandom_range(0, 8000)) - 4000);
      c.y2 = POS_W'(c.y1 + $signed($urandom_range(0, 8000)) - 4000);
      if ($urandom_range(0, 3) == 0) begin
         c.x2 = POS_W'($urandom); c.y2 = POS_W'($urandom);
      end
      if ($urandom_range(0, 30) == 0) begin
         c.x2 = c.x1; c.y2 = c.y1;
      end
      case ($urandom_range(0, 5))
         0: c.w1 = '0;
         1: c.w1 = 16'hFFFF;
         default: c.w1 = WGT_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0: c.w2 = '0;
         1: c.w2 = 16'hFFFF;
         default: c.w2 = WGT_W'($urandom);
      endcase
      return c;
   endfunction

   task automatic drain();
      while (pending_q.size() > 0 || expected_moves.size() > 0 || req_valid)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_REST_LENGTH) rest_len_q = val;
      else stiff_q = val[K_W-1:0];
   endtask

   initial begin
      logic [REST_W-1:0] rests[5];
      logic [K_W-1:0]    stiffs[5];
      pair_type c;
      rests  = '{24'd0, 24'd256, 24'd2560, 24'hFFFFFF, 24'd40000};
      stiffs = '{K_ONE, 17'd0, 17'd32768, 17'h1FFFF, 17'd1};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, fixed particles, skips
      pending_q.push_back('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
                            16'hFFFF, 16'hFFFF});
      pending_q.push_back('{24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000,
                            16'h0001, 16'h0000});
      pending_q.push_back('{24'sd100, 24'sd200, 24'sd100, 24'sd200, 16'd256, 16'd256});
      pending_q.push_back('{24'sd100, 24'sd200, 24'sd900, 24'sd5, 16'd0, 16'd0});
      pending_q.push_back('{24'sd0, 24'sd0, 24'sd1, 24'sd0, 16'd256, 16'd0});
      pending_q.push_back('{24'sd0, 24'sd0, 24'sd0, -24'sd1, 16'd0, 16'hFFFF});
      pending_q.push_back('{24'sd512, -24'sd512, -24'sd512, 24'sd512, 16'd256, 16'd512});
      pending_q.push_back('{24'sh555555, 24'shAAAAAA, 24'shAAAAAA, 24'sh555555,
                            16'h5555, 16'hAAAA});
      drain();

      // sweep register settings; random constraints per phase
      for (int p = 0; p < 5; p++) begin
         write_reg(CSR_REST_LENGTH, rests[p]);
         write_reg(CSR_STIFFNESS, {7'd0, stiffs[p]});
         for (int i = 0; i < NUM_RAND / 5; i++) begin
            c = rand_pair();
            pending_q.push_back(c);
         end
         if (p == 4) calm = 1'b1;
         if (p == 2) begin
            // sender pause mid-phase until the block has fully drained
            while (pending_q.size() > NUM_RAND / 10) @(posedge clock);
            hold_off = 1'b1;
            while (expected_moves.size() > 0 || req_valid) @(posedge clock);
            hold_off = 1'b0;
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("PASS distance_constraint_projection");
      end else begin
         $display("FAIL distance_constraint_projection");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/dcp_pkg.sv
rtl/core/dcp_div.sv
rtl/core/distance_constraint_projection.sv
tb/sv/distance_constraint_projection_tb.sv
